FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/rlpf_pkg.sv
`timescale 1ns / 1ps

package rlpf_pkg;

  // Number of palette entries a request may select (1 to 9).
  localparam int unsigned VALID_COLORS = 7;
  localparam int unsigned PAL_SIZE     = 9;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FADE_STEP_TICKS  = 3'd0,
    CFG_SLOW_FLASH_COUNT = 3'd1,
    CFG_SLOW_FLASH_TICKS = 3'd2,
    CFG_FAST_FLASH_COUNT = 3'd3,
    CFG_FAST_FLASH_TICKS = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_SET  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    FLASH_NONE = 2'd0,
    FLASH_SLOW = 2'd1,
    FLASH_FAST = 2'd2
  } flash_mode_e;

  typedef struct packed {
    logic [15:0] fade_step_ticks;
    logic [7:0]  slow_flash_count;
    logic [15:0] slow_flash_ticks;
    logic [7:0]  fast_flash_count;
    logic [15:0] fast_flash_ticks;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  typedef struct packed {
    logic [7:0] red_drive;
    logic [7:0] green_drive;
    logic [7:0] blue_drive;
    logic       busy_res;
    logic       request_dropped;
  } res_t;

  localparam color_t ColorBlack   = '{red: 8'd0,   green: 8'd0, blue: 8'd0};
  localparam color_t ColorMagenta = '{red: 8'd255, green: 8'd0, blue: 8'd255};
  localparam logic [3:0] IdxWhite = 4'd6;

  // Fixed palette; anything past the last entry reads as black.
  function automatic color_t palette_color(logic [3:0] idx);
    color_t c;
    case (idx)
      4'd0:    c = '{red: 8'd255, green: 8'd128, blue: 8'd128};
      4'd1:    c = '{red: 8'd255, green: 8'd255, blue: 8'd0};
      4'd2:    c = '{red: 8'd255, green: 8'd96,  blue: 8'd0};
      4'd3:    c = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
      4'd4:    c = '{red: 8'd0,   green: 8'd255, blue: 8'd0};
      4'd5:    c = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
      4'd6:    c = '{red: 8'd255, green: 8'd255, blue: 8'd255};
      4'd7:    c = ColorMagenta;
      default: c = ColorBlack;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] step_toward(logic [7:0] v, logic [7:0] t);
    logic [7:0] r;
    if (v < t) begin
      r = v + 8'd1;
    end else if (v > t) begin
      r = v - 8'd1;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

FILE: rtl/rlpf_intf.sv
`timescale 1ns / 1ps

// Request stream into the block.
interface rlpf_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [3:0] color_id;
  logic [1:0] flash_mode;

  modport source (output valid, command, color_id, flash_mode, input ready);
  modport sink   (input valid, command, color_id, flash_mode, output ready);
endinterface

// Result stream out of the block.
interface rlpf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_drive;
  logic [7:0] green_drive;
  logic [7:0] blue_drive;
  logic       busy_res;
  logic       request_dropped;

  modport source (output valid, red_drive, green_drive, blue_drive, busy_res,
                  request_dropped, input ready);
  modport sink   (input valid, red_drive, green_drive, blue_drive, busy_res,
                  request_dropped, output ready);
endinterface

// Register write channel.
interface rlpf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rlpf_pkg::CfgIdxW-1:0]  index;
  logic [rlpf_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/rlpf_cfg_regs.sv
`timescale 1ns / 1ps

module rlpf_cfg_regs (
  input  logic            clk_i,
  input  logic            rst_ni,
  rlpf_cfg_if.sink        cfg_i,
  output rlpf_pkg::cfg_t  cfg_o
);

  rlpf_pkg::cfg_t cfg_q, cfg_d;

  // Always take writes; unknown indexes are dropped.
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (rlpf_pkg::cfg_idx_e'(cfg_i.index))
        rlpf_pkg::CFG_FADE_STEP_TICKS:  cfg_d.fade_step_ticks  = cfg_i.data;
        rlpf_pkg::CFG_SLOW_FLASH_COUNT: cfg_d.slow_flash_count = cfg_i.data[7:0];
        rlpf_pkg::CFG_SLOW_FLASH_TICKS: cfg_d.slow_flash_ticks = cfg_i.data;
        rlpf_pkg::CFG_FAST_FLASH_COUNT: cfg_d.fast_flash_count = cfg_i.data[7:0];
        rlpf_pkg::CFG_FAST_FLASH_TICKS: cfg_d.fast_flash_ticks = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fade_step_ticks  <= 16'd10;
      cfg_q.slow_flash_count <= 8'd6;
      cfg_q.slow_flash_ticks <= 16'd500;
      cfg_q.fast_flash_count <= 8'd12;
      cfg_q.fast_flash_ticks <= 16'd250;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/rlpf_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rlpf_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rlpf_pkg::cfg_t  cfg_i,
  rlpf_in_if.sink         in_i,
  input  logic            ready_i,
  output logic            accept_o,
  output rlpf_pkg::res_t  res_o
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_FADE = 2'd1,
    PH_DARK = 2'd2,
    PH_LIT  = 2'd3
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [3:0]           cur_q, cur_d;
  logic [3:0]           target_q, target_d;
  rlpf_pkg::color_t     level_q, level_d;
  logic [15:0]          wait_q, wait_d;
  logic [7:0]           blinks_q, blinks_d;
  logic [1:0]           pending_q, pending_d;
  logic                 dropped;

  logic                 accept;
  logic                 is_set;
  logic                 id_ok;
  logic [1:0]           fl_mode;
  logic                 fl_on;
  logic [7:0]           fl_count;
  logic [15:0]          fl_ticks;
  logic [7:0]           blinks_dec;
  rlpf_pkg::color_t     tgt_color;
  rlpf_pkg::color_t     cur_color;
  rlpf_pkg::color_t     req_color;
  rlpf_pkg::color_t     base_color;
  rlpf_pkg::color_t     step_color;

  assign in_i.ready = ready_i;
  assign accept     = in_i.valid && ready_i;
  assign accept_o   = accept;
  assign is_set     = (in_i.command == rlpf_pkg::CMD_SET);

  assign id_ok = (in_i.color_id < 4'(rlpf_pkg::VALID_COLORS)) &&
                 (in_i.color_id < 4'(rlpf_pkg::PAL_SIZE));

  // Flash settings: a new request uses its own mode, ticks use the stored one.
  assign fl_mode  = is_set ? in_i.flash_mode : pending_q;
  assign fl_on    = (fl_mode == rlpf_pkg::FLASH_SLOW) || (fl_mode == rlpf_pkg::FLASH_FAST);
  assign fl_count = (fl_mode == rlpf_pkg::FLASH_SLOW) ? cfg_i.slow_flash_count
                                                      : cfg_i.fast_flash_count;
  assign fl_ticks = (fl_mode == rlpf_pkg::FLASH_SLOW) ? cfg_i.slow_flash_ticks
                                                      : cfg_i.fast_flash_ticks;
  assign blinks_dec = (blinks_q != 8'd0) ? blinks_q - 8'd1 : 8'd0;

  // Palette reads and one fade step toward the target.
  assign tgt_color  = rlpf_pkg::palette_color(target_q);
  assign cur_color  = rlpf_pkg::palette_color(cur_q);
  assign req_color  = rlpf_pkg::palette_color(in_i.color_id);
  assign base_color = is_set ? cur_color : level_q;

  always_comb begin
    rlpf_pkg::color_t goal;
    goal = is_set ? req_color : tgt_color;
    step_color.red   = rlpf_pkg::step_toward(base_color.red,   goal.red);
    step_color.green = rlpf_pkg::step_toward(base_color.green, goal.green);
    step_color.blue  = rlpf_pkg::step_toward(base_color.blue,  goal.blue);
  end

  // Advance the sequence by one request.
  always_comb begin
    phase_d   = phase_q;
    cur_d     = cur_q;
    target_d  = target_q;
    level_d   = level_q;
    wait_d    = wait_q;
    blinks_d  = blinks_q;
    pending_d = pending_q;
    dropped   = 1'b0;
    if (accept) begin
      if (!is_set) begin
        if (phase_q != PH_IDLE) begin
          if (wait_q > 16'd1) begin
            wait_d = wait_q - 16'd1;
          end else begin
            wait_d = 16'd0;
            case (phase_q)
              PH_FADE: begin
                if (level_q == tgt_color) begin
                  cur_d = target_q;
                  if (!fl_on) begin
                    phase_d = PH_IDLE;
                  end else begin
                    blinks_d = fl_count;
                    if (fl_count == 8'd0) begin
                      phase_d = PH_IDLE;
                    end else begin
                      phase_d = PH_DARK;
                      level_d = rlpf_pkg::ColorBlack;
                      wait_d  = fl_ticks;
                    end
                  end
                end else begin
                  level_d = step_color;
                  wait_d  = cfg_i.fade_step_ticks;
                end
              end
              PH_DARK: begin
                phase_d = PH_LIT;
                level_d = cur_color;
                wait_d  = fl_ticks;
              end
              PH_LIT: begin
                blinks_d = blinks_dec;
                if (blinks_dec == 8'd0) begin
                  phase_d = PH_IDLE;
                end else begin
                  phase_d = PH_DARK;
                  level_d = rlpf_pkg::ColorBlack;
                  wait_d  = fl_ticks;
                end
              end
              default: ;
            endcase
          end
        end
      end else if (phase_q != PH_IDLE) begin
        dropped = 1'b1;
      end else begin
        pending_d = in_i.flash_mode;
        if (id_ok) begin
          target_d = in_i.color_id;
          level_d  = step_color;
          phase_d  = PH_FADE;
          wait_d   = cfg_i.fade_step_ticks;
        end else if (fl_on) begin
          blinks_d = fl_count;
          if (fl_count != 8'd0) begin
            phase_d = PH_DARK;
            level_d = rlpf_pkg::ColorBlack;
            wait_d  = fl_ticks;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      cur_q     <= rlpf_pkg::IdxWhite;
      target_q  <= 4'd0;
      level_q   <= rlpf_pkg::ColorMagenta;
      wait_q    <= 16'd0;
      blinks_q  <= 8'd0;
      pending_q <= 2'd0;
    end else begin
      phase_q   <= phase_d;
      cur_q     <= cur_d;
      target_q  <= target_d;
      level_q   <= level_d;
      wait_q    <= wait_d;
      blinks_q  <= blinks_d;
      pending_q <= pending_d;
    end
  end

  // Result reflects the state after this request.
  assign res_o.red_drive       = ~level_d.red;
  assign res_o.green_drive     = ~level_d.green;
  assign res_o.blue_drive      = ~level_d.blue;
  assign res_o.busy_res        = (phase_d != PH_IDLE);
  assign res_o.request_dropped = dropped;

  `ASSERT_IMPL(a_idle_wait_clear, clk_i, rst_ni, phase_q == PH_IDLE, wait_q == 16'd0)
  `ASSERT_IMPL(a_dark_is_black, clk_i, rst_ni, phase_q == PH_DARK,
               level_q == rlpf_pkg::ColorBlack)
  `ASSERT_NEXT(a_drop_keeps_levels, clk_i, rst_ni,
               accept && is_set && (phase_q != PH_IDLE), $stable(level_q))

endmodule

FILE: rtl/rlpf_out_buf.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rlpf_out_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rlpf_pkg::res_t  res_i,
  output logic            ready_o,
  rlpf_out_if.source      out_o
);

  logic           main_valid_q, skid_valid_q;
  rlpf_pkg::res_t main_q, skid_q;
  logic           drain;

  // Take a new result whenever the skid slot is free.
  assign ready_o = !skid_valid_q;
  assign drain   = !main_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (drain) begin
      main_valid_q <= skid_valid_q || push_i;
      skid_valid_q <= 1'b0;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload moves without reset.
  always_ff @(posedge clk_i) begin
    if (drain) begin
      main_q <= skid_valid_q ? skid_q : res_i;
    end else if (push_i) begin
      skid_q <= res_i;
    end
  end

  assign out_o.valid           = main_valid_q;
  assign out_o.red_drive       = main_q.red_drive;
  assign out_o.green_drive     = main_q.green_drive;
  assign out_o.blue_drive      = main_q.blue_drive;
  assign out_o.busy_res        = main_q.busy_res;
  assign out_o.request_dropped = main_q.request_dropped;

  `ASSERT_IMPL(a_skid_behind_main, clk_i, rst_ni, skid_valid_q, main_valid_q)
  `ASSERT_NEXT(a_stall_fills_skid, clk_i, rst_ni,
               main_valid_q && !out_o.ready && push_i, skid_valid_q)

endmodule

FILE: rtl/rgb_led_palette_fader_flasher.sv
`timescale 1ns / 1ps

// RGB LED palette fader and flasher for a common-anode LED. Every accepted
// request, a 1 ms tick or a color request, produces one result carrying the
// inverted drive levels, a busy flag and a dropped-request flag. A request is
// taken in every cycle while the skid slot of the output buffer is free: the
// sequence state updates in a single registered pass and the result is
// registered into a two-entry output buffer, which keeps input ready high
// while one result waits downstream. Register writes take effect in the cycle
// after the write and should be made while no results are outstanding.
module rgb_led_palette_fader_flasher (
  input  logic     clk_i,
  input  logic     rst_ni,
  rlpf_cfg_if.sink cfg_i,
  rlpf_in_if.sink  in_i,
  rlpf_out_if.source out_o
);

  rlpf_pkg::cfg_t cfg;
  rlpf_pkg::res_t res;
  logic           buf_ready;
  logic           accept;

  rlpf_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  rlpf_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .in_i     (in_i),
    .ready_i  (buf_ready),
    .accept_o (accept),
    .res_o    (res)
  );

  rlpf_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .res_i   (res),
    .ready_o (buf_ready),
    .out_o   (out_o)
  );

endmodule
